// ===== design/dlrs_pkg.sv =====
// Shared types and constants for the deduplicating LIFO request stack.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dlrs_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 512;
   localparam int CMD_QUEUE_DEPTH     = 2;
   localparam int LEVEL_W             = 3;
   localparam int COORD_W             = 20;
   localparam int KEY_W               = LEVEL_W + 3 * COORD_W;
   localparam int OCC_W               = 10;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [2:0] {
      STATUS_PUSHED      = 3'd0,
      STATUS_PUSHED_DROP = 3'd1,
      STATUS_DUPLICATE   = 3'd2,
      STATUS_POPPED      = 3'd3,
      STATUS_EMPTY       = 3'd4
   } dlrs_status_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_SCAN,
      ENG_WRITE,
      ENG_POP_DATA,
      ENG_FINISH
   } dlrs_eng_state_type;

   typedef struct packed {
      logic               op;
      logic [LEVEL_W-1:0] level;
      logic [COORD_W-1:0] region_z;
      logic [COORD_W-1:0] region_y;
      logic [COORD_W-1:0] region_x;
   } dlrs_req_type;

   typedef struct packed {
      dlrs_status_type    status;
      logic [LEVEL_W-1:0] out_level;
      logic [COORD_W-1:0] out_z;
      logic [COORD_W-1:0] out_y;
      logic [COORD_W-1:0] out_x;
      logic [OCC_W-1:0]   occupancy;
   } dlrs_rsp_type;

   typedef struct packed {
      logic             is_pop;
      logic [KEY_W-1:0] key;
   } dlrs_cmd_type;

endpackage

`default_nettype wire

// ===== design/dedup_lifo_request_stack.sv =====
// Usage: push or pop region requests over req_valid/req_ready/req_data; one
// response transaction per request comes back on rsp_valid/rsp_ready/rsp_data
// with a status, the popped key (zero otherwise) and the occupancy after it.
// A push whose key is already stored is reported as duplicate and ignored;
// a push on a full stack drops the oldest entry.
// Sequence: a pop reads the top entry, then passes POP_DATA and FINISH
// (an empty pop goes straight to FINISH). A push runs the duplicate scan,
// which reads one RAM entry per cycle, then WRITE and FINISH; a match goes
// straight to FINISH, so a push lasts longer the more entries are stored.
// The engine handles one command at a time and takes the next only in IDLE.
// A two-entry command queue takes new transactions while the engine works, and
// the response register holds one finished transaction while the engine
// completes the next. When rsp_ready stays low, the engine waits with its
// result and the command queue fills, then req_ready drops.
// Reset clears the queue, the count and the bottom pointer; the key RAM is
// not cleared and no entry is read before it is written.
// Depends on dlrs_pkg, dlrs_front and dlrs_engine.
`timescale 1ns / 1ps
`default_nettype none

module dedup_lifo_request_stack #(
   parameter int MAX_ENTRIES = dlrs_pkg::MAX_ENTRIES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire dlrs_pkg::dlrs_req_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output dlrs_pkg::dlrs_rsp_type     rsp_data
);

   logic                   cmd_valid;
   logic                   cmd_ready;
   dlrs_pkg::dlrs_cmd_type cmd_data;
   logic                   fin_valid;
   logic                   fin_ready;
   dlrs_pkg::dlrs_rsp_type fin_data;

   logic                   rsp_valid_ff, rsp_valid_in;
   dlrs_pkg::dlrs_rsp_type rsp_data_ff, rsp_data_in;

   dlrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   dlrs_engine #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .fin_valid (fin_valid),
      .fin_ready (fin_ready),
      .fin_data  (fin_data)
   );

   assign fin_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fin_ready) begin
         rsp_valid_in = fin_valid;
         if (fin_valid) begin
            rsp_data_in = fin_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== design/dlrs_front.sv =====
// Front end: accepts request transactions, packs them into commands and
// buffers them in a short queue. Depends on dlrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlrs_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire dlrs_pkg::dlrs_req_type req_data,
   output logic                       cmd_valid,
   input  wire logic                  cmd_ready,
   output dlrs_pkg::dlrs_cmd_type     cmd_data
);

   localparam int PW = $clog2(dlrs_pkg::CMD_QUEUE_DEPTH);
   localparam int NW = $clog2(dlrs_pkg::CMD_QUEUE_DEPTH + 1);

   dlrs_pkg::dlrs_cmd_type queue_ff [dlrs_pkg::CMD_QUEUE_DEPTH];
   dlrs_pkg::dlrs_cmd_type new_cmd;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] fill_ff, fill_in;
   logic          push_q;
   logic          pop_q;

   always_comb begin
      new_cmd.is_pop = (req_data.op == dlrs_pkg::OP_POP);
      new_cmd.key    = {req_data.level, req_data.region_z, req_data.region_y,
                        req_data.region_x};
   end

   assign req_ready = (fill_ff != NW'(dlrs_pkg::CMD_QUEUE_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd_data  = queue_ff[rd_ptr_ff];
   assign push_q    = req_valid && req_ready;
   assign pop_q     = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_q) begin
         wr_ptr_in = (wr_ptr_ff == PW'(dlrs_pkg::CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_q) begin
         rd_ptr_in = (rd_ptr_ff == PW'(dlrs_pkg::CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_q && !pop_q) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop_q && !push_q) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_q) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== design/dlrs_engine.sv =====
// Back end: key storage RAM, duplicate scan, push/pop sequencer.
// Depends on dlrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlrs_engine #(
   parameter int MAX_ENTRIES = dlrs_pkg::MAX_ENTRIES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   output logic                       cmd_ready,
   input  wire dlrs_pkg::dlrs_cmd_type cmd_data,
   output logic                       fin_valid,
   input  wire logic                  fin_ready,
   output dlrs_pkg::dlrs_rsp_type     fin_data
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int KW = dlrs_pkg::KEY_W;
   localparam int CO = dlrs_pkg::COORD_W;

   logic [KW-1:0] mem [MAX_ENTRIES];

   dlrs_pkg::dlrs_eng_state_type state_ff, state_in;
   logic [KW-1:0]          key_ff, key_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          bottom_ff, bottom_in;
   logic [CW-1:0]          pos_ff, pos_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic [KW-1:0]          rdata_ff;
   dlrs_pkg::dlrs_rsp_type res_ff, res_in;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          match;
   logic          full;
   logic          issue_done;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [AW-1:0] pos);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, pos};
      if (sum >= (AW+1)'(MAX_ENTRIES)) begin
         sum = sum - (AW+1)'(MAX_ENTRIES);
      end
      return sum[AW-1:0];
   endfunction

   assign match      = cmp_valid_ff && (rdata_ff == key_ff);
   assign full       = (count_ff == CW'(MAX_ENTRIES));
   assign issue_done = (pos_ff == count_ff);
   assign fin_valid  = (state_ff == dlrs_pkg::ENG_FINISH);
   assign fin_data   = res_ff;
   assign cmd_ready  = (state_ff == dlrs_pkg::ENG_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dlrs_pkg::ENG_IDLE: begin
            if (cmd_valid) begin
               if (cmd_data.is_pop) begin
                  state_in = (count_ff == '0) ? dlrs_pkg::ENG_FINISH : dlrs_pkg::ENG_POP_DATA;
               end else begin
                  state_in = (count_ff == '0) ? dlrs_pkg::ENG_WRITE : dlrs_pkg::ENG_SCAN;
               end
            end
         end
         dlrs_pkg::ENG_SCAN: begin
            if (match) begin
               state_in = dlrs_pkg::ENG_FINISH;
            end else if (issue_done) begin
               state_in = dlrs_pkg::ENG_WRITE;
            end
         end
         dlrs_pkg::ENG_WRITE:    state_in = dlrs_pkg::ENG_FINISH;
         dlrs_pkg::ENG_POP_DATA: state_in = dlrs_pkg::ENG_FINISH;
         dlrs_pkg::ENG_FINISH: begin
            if (fin_ready) begin
               state_in = dlrs_pkg::ENG_IDLE;
            end
         end
         default: state_in = dlrs_pkg::ENG_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      key_in       = key_ff;
      count_in     = count_ff;
      bottom_in    = bottom_ff;
      pos_in       = pos_ff;
      cmp_valid_in = 1'b0;
      res_in       = res_ff;
      rd_en        = 1'b0;
      rd_addr      = slot_of(bottom_ff, pos_ff[AW-1:0]);
      wr_en        = 1'b0;
      wr_addr      = slot_of(bottom_ff, count_ff[AW-1:0]);
      case (state_ff)
         dlrs_pkg::ENG_IDLE: begin
            if (cmd_valid) begin
               res_in = '0;
               if (cmd_data.is_pop) begin
                  if (count_ff == '0) begin
                     res_in.status    = dlrs_pkg::STATUS_EMPTY;
                     res_in.occupancy = dlrs_pkg::OCC_W'(count_ff);
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = slot_of(bottom_ff, AW'(count_ff - 1'b1));
                     count_in = count_ff - 1'b1;
                  end
               end else begin
                  key_in = cmd_data.key;
                  pos_in = '0;
               end
            end
         end
         dlrs_pkg::ENG_SCAN: begin
            if (!issue_done) begin
               rd_en        = 1'b1;
               pos_in       = pos_ff + 1'b1;
               cmp_valid_in = 1'b1;
            end
            if (match) begin
               res_in.status    = dlrs_pkg::STATUS_DUPLICATE;
               res_in.occupancy = dlrs_pkg::OCC_W'(count_ff);
            end
         end
         dlrs_pkg::ENG_WRITE: begin
            wr_en = 1'b1;
            if (full) begin
               // overwrite the oldest slot, which becomes the new top
               wr_addr          = bottom_ff;
               bottom_in        = (bottom_ff == AW'(MAX_ENTRIES - 1)) ? '0 : bottom_ff + 1'b1;
               res_in.status    = dlrs_pkg::STATUS_PUSHED_DROP;
               res_in.occupancy = dlrs_pkg::OCC_W'(count_ff);
            end else begin
               count_in         = count_ff + 1'b1;
               res_in.status    = dlrs_pkg::STATUS_PUSHED;
               res_in.occupancy = dlrs_pkg::OCC_W'(count_in);
            end
         end
         dlrs_pkg::ENG_POP_DATA: begin
            res_in.status    = dlrs_pkg::STATUS_POPPED;
            res_in.out_level = rdata_ff[KW-1 -: dlrs_pkg::LEVEL_W];
            res_in.out_z     = rdata_ff[3*CO-1 -: CO];
            res_in.out_y     = rdata_ff[2*CO-1 -: CO];
            res_in.out_x     = rdata_ff[CO-1:0];
            res_in.occupancy = dlrs_pkg::OCC_W'(count_ff);
         end
         dlrs_pkg::ENG_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlrs_pkg::ENG_IDLE;
         count_ff     <= '0;
         bottom_ff    <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bottom_ff    <= bottom_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pos_ff <= pos_in;
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= key_ff;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count above stack depth");

   a_bottom_bound: assert property (@(posedge clock) disable iff (reset)
      bottom_ff < AW'(MAX_ENTRIES - 1) || bottom_ff == AW'(MAX_ENTRIES - 1))
      else $error("bottom slot out of range");

   a_scan_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == dlrs_pkg::ENG_SCAN |-> pos_ff <= count_ff)
      else $error("scan ran past the stored entries");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dlrs_pkg::ENG_WRITE && !full) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not grow the stack");

   a_drop_keeps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dlrs_pkg::ENG_WRITE && full) |=> count_ff == CW'(MAX_ENTRIES))
      else $error("push on full stack changed the count");

endmodule

`default_nettype wire
